[src/swhc_pkg.sv]
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared types, constants and helpers of the sliding-window heterozygosity
// counter.
// ----------------------------------------------------------------------------
package swhc_pkg;

	// Sizing
	localparam int MAX_WINDOW    = 65536;
	localparam int POSITION_BITS = 32;
	localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
	localparam int WIN_BITS      = $clog2(MAX_WINDOW + 1);

	// Fixed field widths
	localparam int CFG_BITS     = 17;
	localparam int STEP_BITS    = 17;
	localparam int CNT_BITS     = 17;
	localparam int OUT_POS_BITS = 32;
	localparam int CLS_BITS     = 2;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	// Reset values of the registers
	localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RST = CFG_BITS'(50000);
	localparam logic [CFG_BITS-1:0] STEP_LENGTH_RST = CFG_BITS'(10000);

	// Queue depths
	localparam int CMD_Q_DEPTH = 4;
	localparam int RES_Q_DEPTH = 4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WINDOW_SIZE     = 2'd0,
		CFG_STEP_LENGTH     = 2'd1,
		CFG_LOWER_IS_MASKED = 2'd2
	} cfg_idx_t;

	typedef enum logic [CLS_BITS-1:0] {
		CLS_AMBIG  = 2'd0,
		CLS_SINGLE = 2'd1,
		CLS_HET    = 2'd2
	} cls_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] window_size;
		logic [CFG_BITS-1:0] step_length;
		logic                lower_is_masked;
	} cfg_t;

	// Work item handed from the front end to the counting back end
	typedef struct packed {
		cls_t                     cls;
		logic [SLOT_BITS-1:0]     slot;
		logic                     evict;    // position already past one window
		logic                     bnd;      // step boundary report before add
		logic                     eos;      // last residue of the sequence
		logic                     use_seg;  // end report uses segment counts
		logic [POSITION_BITS-1:0] pos;
		logic [POSITION_BITS-1:0] lb;       // last boundary before this item
	} cmd_t;

	typedef struct packed {
		logic [OUT_POS_BITS-1:0] window_start;
		logic [OUT_POS_BITS-1:0] window_end;
		logic [CNT_BITS-1:0]     informative_count;
		logic [CNT_BITS-1:0]     heterozygous_count;
		logic                    last_of_run;
	} res_t;

	// 0 acts as 1, anything above MAX_WINDOW acts as MAX_WINDOW
	function automatic logic [WIN_BITS-1:0] eff_window(input logic [CFG_BITS-1:0] w);
		logic [WIN_BITS-1:0] r;
		if (w == '0) begin
			r = WIN_BITS'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = WIN_BITS'(MAX_WINDOW);
		end else begin
			r = WIN_BITS'(w);
		end
		return r;
	endfunction

	function automatic cls_t classify(input logic [7:0] b_in, input logic mask_lower);
		logic [7:0] b;
		cls_t       c;
		b = b_in;
		c = CLS_AMBIG;
		if (b >= "a" && b <= "z") begin
			b = b - 8'd32;
		end
		unique case (b)
			"A", "C", "G", "T":           c = CLS_SINGLE;
			"M", "R", "W", "S", "Y", "K": c = CLS_HET;
			default:                      c = CLS_AMBIG;
		endcase
		if (mask_lower && b_in >= "a" && b_in <= "z") begin
			c = CLS_AMBIG;
		end
		return c;
	endfunction

endpackage

[src/swhc_if.sv]
// ----------------------------------------------------------------------------
// swhc_in_if / swhc_out_if
// Valid/ready channels of the heterozygosity counter: residues in, window
// reports out.
// ----------------------------------------------------------------------------
interface swhc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] residue;
	logic       end_of_sequence;

	modport source (output valid, output residue, output end_of_sequence, input ready);
	modport sink   (input valid, input residue, input end_of_sequence, output ready);
endinterface

interface swhc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [swhc_pkg::OUT_POS_BITS-1:0]     window_start;
	logic [swhc_pkg::OUT_POS_BITS-1:0]     window_end;
	logic [swhc_pkg::CNT_BITS-1:0]         informative_count;
	logic [swhc_pkg::CNT_BITS-1:0]         heterozygous_count;
	logic                                  last_of_run;

	modport source (
		output valid, output window_start, output window_end,
		output informative_count, output heterozygous_count, output last_of_run,
		input ready
	);
	modport sink (
		input valid, input window_start, input window_end,
		input informative_count, input heterozygous_count, input last_of_run,
		output ready
	);
endinterface

[src/sliding_window_heterozygosity_counter_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_heterozygosity_counter_core
// Streams residue bytes and reports informative and heterozygous counts over
// a sliding window at every step boundary and at sequence end.
// ----------------------------------------------------------------------------
// One residue transaction is taken per clock unless a slot rebuild or a full
// command queue stalls the input; the front end classes it and the back end's
// single-port-read, single-port-write class ring (one read and one write of
// the same slot per residue) sets that rate. A residue passes through the
// command queue and the ring read stage into a four-entry report queue, which
// takes both reports of a residue that causes two (boundary plus sequence end).
// Writing window_size stalls the input while the ring slot is recomputed as
// position modulo the new window, one remainder step per position bit;
// other register writes take effect at once. The user must write registers
// only while no transaction is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module sliding_window_heterozygosity_counter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	swhc_in_if.sink                             in_ch,
	swhc_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [swhc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [swhc_pkg::CFG_BITS-1:0]       cfg_wdata
);

	swhc_pkg::cfg_t cfg_q;
	logic           win_wr;

	// front to queue
	logic           fe_push, q_full;
	swhc_pkg::cmd_t fe_cmd;

	// queue to back end
	logic           q_not_empty, q_pop;
	swhc_pkg::cmd_t q_head;

	swhc_pkg::res_t res;

	// A window_size write restarts the slot computation in the front end.
	assign win_wr = cfg_we && (cfg_idx == swhc_pkg::CFG_WINDOW_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size     <= swhc_pkg::WINDOW_SIZE_RST;
			cfg_q.step_length     <= swhc_pkg::STEP_LENGTH_RST;
			cfg_q.lower_is_masked <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				swhc_pkg::CFG_WINDOW_SIZE:     cfg_q.window_size     <= cfg_wdata;
				swhc_pkg::CFG_STEP_LENGTH:     cfg_q.step_length     <= cfg_wdata;
				swhc_pkg::CFG_LOWER_IS_MASKED: cfg_q.lower_is_masked <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Front end: classify, boundary detect, position and slot tracking.
	swhc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.win_wr          (win_wr),
		.in_valid        (in_ch.valid),
		.in_ready        (in_ch.ready),
		.residue         (in_ch.residue),
		.end_of_sequence (in_ch.end_of_sequence),
		.push            (fe_push),
		.cmd             (fe_cmd),
		.q_full          (q_full)
	);

	// Decouples the front end from back-end and output stalls.
	swhc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_push),
		.push_data (fe_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back end: ring, counts and report queue.
	swhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.pop       (q_pop),
		.res_valid (out_ch.valid),
		.res       (res),
		.res_ready (out_ch.ready)
	);

	assign out_ch.window_start       = res.window_start;
	assign out_ch.window_end         = res.window_end;
	assign out_ch.informative_count  = res.informative_count;
	assign out_ch.heterozygous_count = res.heterozygous_count;
	assign out_ch.last_of_run        = res.last_of_run;

endmodule

[src/swhc_front.sv]
// ----------------------------------------------------------------------------
// swhc_front
// Accepts residues, classes them and tracks position, step phase, last
// boundary and ring slot. Rebuilds the slot with a serial remainder unit
// after the window size changes.
// ----------------------------------------------------------------------------
module swhc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swhc_pkg::cfg_t        cfg,
	input  logic                  win_wr,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            residue,
	input  logic                  end_of_sequence,
	output logic                  push,
	output swhc_pkg::cmd_t        cmd,
	input  logic                  q_full
);

	localparam int PB  = swhc_pkg::POSITION_BITS;
	localparam int WB  = swhc_pkg::WIN_BITS;
	localparam int SB  = swhc_pkg::SLOT_BITS;
	localparam int STB = swhc_pkg::STEP_BITS;
	localparam int DCB = $clog2(PB);

	logic [PB-1:0]  pos_q, lb_q, dist_q;
	logic [STB-1:0] phase_q;
	logic [SB-1:0]  slot_q;
	logic           div_busy_q;
	logic [DCB-1:0] div_cnt_q;
	logic [WB-1:0]  div_rem_q;
	logic [PB-1:0]  div_quo_q;

	logic [WB-1:0]  win_eff;
	logic [STB-1:0] step_eff;
	logic [PB-1:0]  win_pos, dist_after;
	logic [STB:0]   phase_inc;
	logic [WB-1:0]  slot_inc;
	logic           evict, bnd, accept;
	logic [WB:0]    div_sh;
	logic [WB-1:0]  div_rem_next;

	always_comb begin
		win_eff    = swhc_pkg::eff_window(cfg.window_size);
		step_eff   = (cfg.step_length == '0) ? STB'(1) : cfg.step_length;
		win_pos    = PB'(win_eff);
		evict      = (pos_q >= win_pos);
		bnd        = evict && (phase_q == '0);
		dist_after = (bnd ? '0 : dist_q) + PB'(1);
		phase_inc  = (STB+1)'(phase_q) + (STB+1)'(1);
		slot_inc   = WB'(slot_q) + WB'(1);

		in_ready = !div_busy_q && !q_full;
		accept   = in_valid && in_ready;
		push     = accept;

		cmd.cls     = swhc_pkg::classify(residue, cfg.lower_is_masked);
		cmd.slot    = slot_q;
		cmd.evict   = evict;
		cmd.bnd     = bnd;
		cmd.eos     = end_of_sequence;
		cmd.use_seg = (dist_after <= win_pos);
		cmd.pos     = pos_q;
		cmd.lb      = lb_q;

		// one restoring step of position mod window
		div_sh       = {div_rem_q, div_quo_q[PB-1]};
		div_rem_next = (div_sh >= (WB+1)'(win_eff)) ? WB'(div_sh - (WB+1)'(win_eff))
		                                            : WB'(div_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			lb_q       <= '0;
			dist_q     <= '0;
			phase_q    <= '0;
			slot_q     <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (win_wr) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + DCB'(1);
			if (div_cnt_q == DCB'(PB - 1)) begin
				div_busy_q <= 1'b0;
				slot_q     <= div_rem_next[SB-1:0];
			end
		end else if (accept) begin
			if (end_of_sequence) begin
				pos_q   <= '0;
				lb_q    <= '0;
				dist_q  <= '0;
				phase_q <= '0;
				slot_q  <= '0;
			end else begin
				pos_q   <= pos_q + PB'(1);
				lb_q    <= bnd ? pos_q : lb_q;
				dist_q  <= dist_after;
				phase_q <= (phase_inc >= (STB+1)'(step_eff)) ? '0 : phase_inc[STB-1:0];
				// position wrap restarts the ring at slot zero
				if (slot_inc >= win_eff || pos_q == '1) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_inc[SB-1:0];
				end
			end
		end
	end

	// remainder datapath, no reset needed
	always_ff @(posedge clk) begin
		if (win_wr) begin
			div_rem_q <= '0;
			div_quo_q <= pos_q;
		end else if (div_busy_q) begin
			div_rem_q <= div_rem_next;
			div_quo_q <= {div_quo_q[PB-2:0], 1'b0};
		end
	end

endmodule

[src/swhc_queue.sv]
// ----------------------------------------------------------------------------
// swhc_queue
// Short command queue between the front end and the counting back end.
// ----------------------------------------------------------------------------
module swhc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swhc_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output swhc_pkg::cmd_t head
);

	localparam int D  = swhc_pkg::CMD_Q_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	swhc_pkg::cmd_t mem [D];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full      = (cnt_q == CW'(D));
	assign not_empty = (cnt_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

[src/swhc_back.sv]
// ----------------------------------------------------------------------------
// swhc_back
// Class ring, window and segment counters and report buffer. Pops one command
// per cycle while the report buffer has room for two, reads and rewrites its
// ring slot, then updates the counts and queues up to two reports.
// ----------------------------------------------------------------------------
module swhc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  swhc_pkg::cmd_t cmd,
	output logic           pop,
	output logic           res_valid,
	output swhc_pkg::res_t res,
	input  logic           res_ready
);

	localparam int CB  = swhc_pkg::CNT_BITS;
	localparam int OB  = swhc_pkg::OUT_POS_BITS;
	localparam int PB  = swhc_pkg::POSITION_BITS;
	localparam int D   = swhc_pkg::RES_Q_DEPTH;
	localparam int RPB = $clog2(D);
	localparam int RCB = $clog2(D + 1);

	function automatic logic [CB-1:0] inc_sat(input logic [CB-1:0] v);
		return (v == swhc_pkg::CNT_MAX) ? v : v + CB'(1);
	endfunction

	function automatic logic [CB-1:0] dec_sat(input logic [CB-1:0] v);
		return (v == '0) ? v : v - CB'(1);
	endfunction

	function automatic logic [CB-1:0] info_sum(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB:0] s;
		s = (CB+1)'(a) + (CB+1)'(b);
		return s[CB] ? swhc_pkg::CNT_MAX : s[CB-1:0];
	endfunction

	logic [swhc_pkg::CLS_BITS-1:0] ring_mem [swhc_pkg::MAX_WINDOW];

	logic                          valid_s1;
	swhc_pkg::cmd_t                cmd_s1;
	logic [swhc_pkg::CLS_BITS-1:0] old_cls_s1;

	logic [CB-1:0] wc_single_q, wc_het_q, seg_single_q, seg_het_q;

	swhc_pkg::res_t res_mem [D];
	logic [RPB-1:0] wr_ptr_q, rd_ptr_q;
	logic [RCB-1:0] res_cnt_q;

	logic           retire, res_pop;
	logic [CB-1:0]  wc_s, wc_h, sg_s, sg_h, end_s, end_h, inf0, inf1;
	logic           v0, v1;
	logic [RCB-1:0] npush;
	logic [PB-1:0]  end_start, end_end;
	swhc_pkg::res_t r0, r1;

	always_comb begin
		retire  = valid_s1 && (res_cnt_q <= RCB'(D - 2));
		pop     = cmd_valid && (!valid_s1 || retire);
		res_valid = (res_cnt_q != '0);
		res     = res_mem[rd_ptr_q];
		res_pop = res_valid && res_ready;

		// boundary report sees counts before this residue
		inf0 = info_sum(wc_single_q, wc_het_q);
		v0   = cmd_s1.bnd && (inf0 != '0);

		wc_s = wc_single_q;
		wc_h = wc_het_q;
		sg_s = cmd_s1.bnd ? '0 : seg_single_q;
		sg_h = cmd_s1.bnd ? '0 : seg_het_q;
		if (cmd_s1.evict) begin
			if (old_cls_s1 == swhc_pkg::CLS_SINGLE) wc_s = dec_sat(wc_s);
			if (old_cls_s1 == swhc_pkg::CLS_HET)    wc_h = dec_sat(wc_h);
		end
		if (cmd_s1.cls == swhc_pkg::CLS_SINGLE) begin
			wc_s = inc_sat(wc_s);
			sg_s = inc_sat(sg_s);
		end
		if (cmd_s1.cls == swhc_pkg::CLS_HET) begin
			wc_h = inc_sat(wc_h);
			sg_h = inc_sat(sg_h);
		end

		end_s     = cmd_s1.use_seg ? sg_s : wc_s;
		end_h     = cmd_s1.use_seg ? sg_h : wc_h;
		inf1      = info_sum(end_s, end_h);
		v1        = cmd_s1.eos && (inf1 != '0);
		end_start = cmd_s1.bnd ? cmd_s1.pos : cmd_s1.lb;
		end_end   = cmd_s1.pos + PB'(1);

		r0.window_start       = cmd_s1.lb[OB-1:0];
		r0.window_end         = cmd_s1.pos[OB-1:0];
		r0.informative_count  = inf0;
		r0.heterozygous_count = wc_het_q;
		r0.last_of_run        = !v1;

		r1.window_start       = end_start[OB-1:0];
		r1.window_end         = end_end[OB-1:0];
		r1.informative_count  = inf1;
		r1.heterozygous_count = end_h;
		r1.last_of_run        = 1'b1;

		npush = retire ? (RCB'(v0) + RCB'(v1)) : '0;
	end

	// ring: read old class and write new one at the same slot
	always_ff @(posedge clk) begin
		if (pop) begin
			old_cls_s1          <= ring_mem[cmd.slot];
			ring_mem[cmd.slot]  <= cmd.cls;
			cmd_s1              <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			if (v0) res_mem[wr_ptr_q] <= r0;
			if (v1) res_mem[v0 ? wr_ptr_q + RPB'(1) : wr_ptr_q] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			wc_single_q  <= '0;
			wc_het_q     <= '0;
			seg_single_q <= '0;
			seg_het_q    <= '0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			res_cnt_q    <= '0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				if (cmd_s1.eos) begin
					wc_single_q  <= '0;
					wc_het_q     <= '0;
					seg_single_q <= '0;
					seg_het_q    <= '0;
				end else begin
					wc_single_q  <= wc_s;
					wc_het_q     <= wc_h;
					seg_single_q <= sg_s;
					seg_het_q    <= sg_h;
				end
			end
			wr_ptr_q  <= wr_ptr_q + RPB'(npush);
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + RPB'(1);
			end
			res_cnt_q <= res_cnt_q + npush - RCB'(res_pop);
		end
	end

endmodule

[src/swhc_checker.sv]
// ----------------------------------------------------------------------------
// swhc_checker
// Port-level checks of the heterozygosity counter, bound to the top level.
// ----------------------------------------------------------------------------
module swhc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [swhc_pkg::OUT_POS_BITS-1:0]   window_start,
	input logic [swhc_pkg::OUT_POS_BITS-1:0]   window_end,
	input logic [swhc_pkg::CNT_BITS-1:0]       informative_count,
	input logic [swhc_pkg::CNT_BITS-1:0]       heterozygous_count,
	input logic                                last_of_run,
	input logic                                cfg_we,
	input logic [swhc_pkg::CFG_IDX_BITS-1:0]   cfg_idx
);

	// stalled report holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_start)
		&& $stable(window_end) && $stable(informative_count)
		&& $stable(heterozygous_count) && $stable(last_of_run))
		else $error("report changed while stalled");

	// empty windows are never reported
	a_inf_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> informative_count != '0)
		else $error("report with zero informative count");

	a_het_le_inf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heterozygous_count <= informative_count)
		else $error("heterozygous count exceeds informative count");

	// slot rebuild blocks input after a window change
	a_win_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_idx == swhc_pkg::CFG_WINDOW_SIZE |=> !in_ready)
		else $error("input taken during slot rebuild");

endmodule

bind sliding_window_heterozygosity_counter_core swhc_checker u_swhc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (in_ch.ready),
	.out_valid          (out_ch.valid),
	.out_ready          (out_ch.ready),
	.window_start       (out_ch.window_start),
	.window_end         (out_ch.window_end),
	.informative_count  (out_ch.informative_count),
	.heterozygous_count (out_ch.heterozygous_count),
	.last_of_run        (out_ch.last_of_run),
	.cfg_we             (cfg_we),
	.cfg_idx            (cfg_idx)
);

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the sliding-window heterozygosity counter. Residues
// go in over a valid/ready channel while an in-bench model of the window and
// segment tallies predicts every report not typed into the directed table;
// reports coming out are matched in order, field by field. A short directed
// table runs first, then a pressure phase and random traffic.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS  = 1530;
	localparam int SETTLE_CYCLES = 16;   // lets late reports show after the last residue
	localparam int HOLD_CYCLES   = 300;  // long output hold-off for back-pressure
	localparam int DRAIN_LIMIT   = 20000;

	// ------------------------------------------------------------------
	// Clock, reset, channels, config port
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	swhc_in_if  in_ch ();
	swhc_out_if out_ch ();

	logic                              cfg_we;
	logic [swhc_pkg::CFG_IDX_BITS-1:0] cfg_idx;
	logic [swhc_pkg::CFG_BITS-1:0]     cfg_wdata;

	sliding_window_heterozygosity_counter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	swhc_pkg::res_t pending_reports [$];   // predicted reports, oldest first
	int   failures;
	bit   quiet;                 // no random idling on either side while set
	bit   hold_out;              // asks the receiver for one long hold-off

	byte unsigned single_codes [4] = '{"A", "C", "G", "T"};
	byte unsigned het_codes    [6] = '{"M", "R", "W", "S", "Y", "K"};

	// ------------------------------------------------------------------
	// Window model: registers, class ring, tallies, position
	// ------------------------------------------------------------------
	logic [swhc_pkg::CFG_BITS-1:0] reg_window;
	logic [swhc_pkg::CFG_BITS-1:0] reg_step;
	logic                          reg_mask;

	swhc_pkg::cls_t ring_cls [swhc_pkg::MAX_WINDOW];
	int unsigned win_tally [2];   // [0] single, [1] het, over the window
	int unsigned seg_tally [2];   // same, since the last boundary
	logic [31:0] seq_pos;
	logic [31:0] last_bnd;
	int unsigned step_ph;

	function automatic void clear_sequence();
		win_tally = '{0, 0};
		seg_tally = '{0, 0};
		seq_pos   = '0;
		last_bnd  = '0;
		step_ph   = 0;
	endfunction

	function automatic void reset_predictor();
		foreach (ring_cls[i]) ring_cls[i] = swhc_pkg::CLS_AMBIG;
		clear_sequence();
		reg_window = swhc_pkg::WINDOW_SIZE_RST;
		reg_step   = swhc_pkg::STEP_LENGTH_RST;
		reg_mask   = 1'b0;
	endfunction

	// zero behaves as one, oversize clamps to the ring depth
	function automatic int unsigned active_window();
		if (reg_window == '0) return 1;
		if (reg_window > swhc_pkg::MAX_WINDOW) return swhc_pkg::MAX_WINDOW;
		return reg_window;
	endfunction

	function automatic swhc_pkg::cls_t residue_class(input logic [7:0] r);
		logic [7:0] u;
		u = r;
		if (r >= "a" && r <= "z") begin
			if (reg_mask) return swhc_pkg::CLS_AMBIG;
			u = r - 8'd32;
		end
		unique case (u)
			"A", "C", "G", "T":           return swhc_pkg::CLS_SINGLE;
			"M", "R", "W", "S", "Y", "K": return swhc_pkg::CLS_HET;
			default:                      return swhc_pkg::CLS_AMBIG;
		endcase
	endfunction

	// builds one report; returns 0 when nothing informative was seen
	function automatic bit form_report(input logic [31:0] from, input logic [31:0] to,
			input int unsigned single, input int unsigned het,
			output swhc_pkg::res_t rep);
		int unsigned inf;
		inf = single + het;
		if (inf > swhc_pkg::CNT_MAX) inf = swhc_pkg::CNT_MAX;
		rep = '{window_start: from, window_end: to, informative_count: inf[16:0],
			heterozygous_count: het[16:0], last_of_run: 1'b0};
		return inf != 0;
	endfunction

	// advances the model by one accepted residue and returns its reports
	function automatic void tally_residue(input logic [7:0] r, input logic eos,
			output swhc_pkg::res_t reps [2], output int n);
		int unsigned    win;
		int unsigned    step;
		int unsigned    slot;
		int unsigned    k;
		swhc_pkg::cls_t c;
		swhc_pkg::cls_t leaving;
		swhc_pkg::res_t rep;
		logic [31:0]    seg_len;
		n    = 0;
		win  = active_window();
		step = (reg_step == '0) ? 1 : reg_step;
		c    = residue_class(r);

		// step boundary is checked before the residue joins the window
		if (seq_pos >= win && step_ph == 0) begin
			if (form_report(last_bnd, seq_pos, win_tally[0], win_tally[1], rep)) begin
				reps[n] = rep;
				n++;
			end
			last_bnd  = seq_pos;
			seg_tally = '{0, 0};
		end

		slot = seq_pos % win;
		if (seq_pos >= win) begin
			leaving = ring_cls[slot];
			if (leaving != swhc_pkg::CLS_AMBIG) begin
				k = int'(leaving) - 1;
				if (win_tally[k] != 0) win_tally[k]--;
			end
		end
		ring_cls[slot] = c;
		if (c != swhc_pkg::CLS_AMBIG) begin
			k = int'(c) - 1;
			if (win_tally[k] < swhc_pkg::CNT_MAX) win_tally[k]++;
			if (seg_tally[k] < swhc_pkg::CNT_MAX) seg_tally[k]++;
		end
		seq_pos++;
		step_ph = (step_ph + 1 >= step) ? 0 : step_ph + 1;

		if (eos) begin
			// short tail since the boundary: segment tallies, else the window
			seg_len = seq_pos - last_bnd;
			if (seg_len <= win) begin
				if (form_report(last_bnd, seq_pos, seg_tally[0], seg_tally[1], rep)) begin
					reps[n] = rep;
					n++;
				end
			end else if (form_report(last_bnd, seq_pos, win_tally[0], win_tally[1], rep)) begin
				reps[n] = rep;
				n++;
			end
			clear_sequence();
		end

		if (n > 0) reps[n-1].last_of_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Report checking
	// ------------------------------------------------------------------
	task automatic note_failure(input string msg);
		failures++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	task automatic check_report();
		swhc_pkg::res_t want;
		if (pending_reports.size() == 0) begin
			note_failure($sformatf("report %0d..%0d with none pending",
				out_ch.window_start, out_ch.window_end));
			return;
		end
		want = pending_reports.pop_front();
		if (out_ch.window_start !== want.window_start)
			note_failure($sformatf("window_start %0d, want %0d",
				out_ch.window_start, want.window_start));
		if (out_ch.window_end !== want.window_end)
			note_failure($sformatf("window_end %0d, want %0d",
				out_ch.window_end, want.window_end));
		if (out_ch.informative_count !== want.informative_count)
			note_failure($sformatf("informative_count %0d, want %0d (end %0d)",
				out_ch.informative_count, want.informative_count, want.window_end));
		if (out_ch.heterozygous_count !== want.heterozygous_count)
			note_failure($sformatf("heterozygous_count %0d, want %0d (end %0d)",
				out_ch.heterozygous_count, want.heterozygous_count, want.window_end));
		if (out_ch.last_of_run !== want.last_of_run)
			note_failure($sformatf("last_of_run %0b, want %0b (end %0d)",
				out_ch.last_of_run, want.last_of_run, want.window_end));
	endtask

	// values sampled at the edge are the pre-edge ones on both sides
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			check_report();
	end

	// ------------------------------------------------------------------
	// Idling
	// ------------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int pause_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
	endfunction

	// Receiver: random ready gaps, plus one long hold-off on request so the
	// report queue and the front end back up into the residue channel.
	initial begin
		int g;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_out) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 25) begin
				out_ch.ready <= 1'b0;
				g = pause_len();
				repeat (g) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offers one residue and returns at the edge that accepts it. valid is
	// left high so back-to-back transactions need no second assignment.
	task automatic offer_residue(input logic [7:0] r, input logic eos);
		int g;
		if (!quiet && $urandom_range(0, 99) < 25) begin
			g = pause_len();
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.residue         <= r;
		in_ch.end_of_sequence <= eos;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
	endtask

	// residue checked against the model
	task automatic feed(input logic [7:0] r, input logic eos);
		swhc_pkg::res_t reps [2];
		int             n;
		offer_residue(r, eos);
		tally_residue(r, eos, reps, n);
		for (int k = 0; k < n; k++) pending_reports.push_back(reps[k]);
	endtask

	// Stops offering, waits for every predicted report, then lets the
	// pipeline settle in case the last residues produced nothing.
	task automatic drain_reports();
		int waited;
		waited = 0;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reports.size() != 0) begin
			note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
			pending_reports.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; the model takes the value at the same edge
	task automatic write_reg(input swhc_pkg::cfg_idx_t which, input int unsigned v);
		cfg_we    <= 1'b1;
		cfg_idx   <= which;
		cfg_wdata <= v[swhc_pkg::CFG_BITS-1:0];
		@(posedge clk);
		unique case (which)
			swhc_pkg::CFG_WINDOW_SIZE:     reg_window = v[swhc_pkg::CFG_BITS-1:0];
			swhc_pkg::CFG_STEP_LENGTH:     reg_step   = v[swhc_pkg::CFG_BITS-1:0];
			swhc_pkg::CFG_LOWER_IS_MASKED: reg_mask   = v[0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// residue mix: letters of both cases, ambiguity codes, raw noise
	function automatic logic [7:0] pick_residue();
		logic [7:0] b;
		int         sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			b = single_codes[$urandom_range(0, 3)];
		else if (sel < 65)
			b = het_codes[$urandom_range(0, 5)];
		else if (sel < 75)
			b = "N";
		else
			return 8'($urandom_range(0, 255));
		if ($urandom_range(0, 2) == 0) b = b + 8'd32;
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		swhc_pkg::cfg_idx_t which;
		int unsigned        value;
		logic [7:0]         residue;
		logic               eos;
		bit                 typed;    // expectation written in the row
		bit                 has_rep;  // typed row expects one report
		swhc_pkg::res_t     rep;
	} row_t;

	row_t plan [$];

	function automatic row_t row_typed(input logic [7:0] r, input logic eos,
			input bit has_rep, input swhc_pkg::res_t rep);
		row_t w;
		w = '{kind: ROW_ITEM, which: swhc_pkg::CFG_WINDOW_SIZE, value: 0, residue: r,
			eos: eos, typed: 1'b1, has_rep: has_rep, rep: rep};
		return w;
	endfunction

	function automatic row_t row_item(input logic [7:0] r, input logic eos);
		row_t w;
		w = row_typed(r, eos, 1'b0, '0);
		w.typed = 1'b0;
		return w;
	endfunction

	function automatic row_t row_cfg(input swhc_pkg::cfg_idx_t which, input int unsigned v);
		row_t w;
		w = row_item(8'h00, 1'b0);
		w.kind  = ROW_CFG;
		w.which = which;
		w.value = v;
		return w;
	endfunction

	// end-of-sequence report as typed in the table
	function automatic swhc_pkg::res_t end_rep(input int unsigned to, input int unsigned inf,
			input int unsigned het);
		return '{window_start: 32'd0, window_end: to, informative_count: inf[16:0],
			heterozygous_count: het[16:0], last_of_run: 1'b1};
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		swhc_pkg::res_t reps [2];
		int             n;
		int             random_fed;
		int             nseq;
		int             len;
		int             sel;
		int unsigned    win;
		int unsigned    v;
		bit             open_tail;

		failures  = 0;
		quiet     = 1'b0;
		hold_out  = 1'b0;
		reset_predictor();

		arst_n                <= 1'b0;
		in_ch.valid           <= 1'b0;
		in_ch.residue         <= 8'h00;
		in_ch.end_of_sequence <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_idx               <= swhc_pkg::CFG_WINDOW_SIZE;
		cfg_wdata             <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings (window 50000, step 10000, unmasked): short
		// sequences only give the end report, over the segment tallies.
		plan.push_back(row_typed("A",   1'b1, 1'b1, end_rep(1, 1, 0)));
		plan.push_back(row_typed("N",   1'b1, 1'b0, '0));
		plan.push_back(row_typed("M",   1'b1, 1'b1, end_rep(1, 1, 1)));
		plan.push_back(row_typed("a",   1'b0, 1'b0, '0));
		plan.push_back(row_typed("k",   1'b1, 1'b1, end_rep(2, 2, 1)));
		plan.push_back(row_typed(8'h00, 1'b1, 1'b0, '0));
		plan.push_back(row_typed(8'hFF, 1'b1, 1'b0, '0));
		// zero window and zero step both act as one; lower case masked
		plan.push_back(row_cfg(swhc_pkg::CFG_WINDOW_SIZE, 0));
		plan.push_back(row_cfg(swhc_pkg::CFG_STEP_LENGTH, 0));
		plan.push_back(row_cfg(swhc_pkg::CFG_LOWER_IS_MASKED, 1));
		plan.push_back(row_item("C", 1'b0));
		plan.push_back(row_item("g", 1'b0));
		plan.push_back(row_item("Y", 1'b0));
		plan.push_back(row_item("T", 1'b0));
		plan.push_back(row_item("K", 1'b1));
		// boundary and end report out of one residue
		plan.push_back(row_item("A", 1'b0));
		plan.push_back(row_item("R", 1'b1));
		// oversize window clamps, oversize step, unmasked lower case again
		plan.push_back(row_cfg(swhc_pkg::CFG_WINDOW_SIZE, 17'h1FFFF));
		plan.push_back(row_cfg(swhc_pkg::CFG_STEP_LENGTH, 17'h1FFFF));
		plan.push_back(row_cfg(swhc_pkg::CFG_LOWER_IS_MASKED, 0));
		plan.push_back(row_typed("b", 1'b1, 1'b0, '0));
		plan.push_back(row_typed("w", 1'b1, 1'b1, end_rep(1, 1, 1)));
		plan.push_back(row_cfg(swhc_pkg::CFG_WINDOW_SIZE, swhc_pkg::MAX_WINDOW));
		plan.push_back(row_cfg(swhc_pkg::CFG_STEP_LENGTH, swhc_pkg::MAX_WINDOW));
		plan.push_back(row_item("U", 1'b0));
		plan.push_back(row_item("S", 1'b1));
		// sequence ending right on a step boundary: end report only
		plan.push_back(row_cfg(swhc_pkg::CFG_WINDOW_SIZE, 3));
		plan.push_back(row_cfg(swhc_pkg::CFG_STEP_LENGTH, 2));
		plan.push_back(row_item("A", 1'b0));
		plan.push_back(row_item("C", 1'b0));
		plan.push_back(row_item("M", 1'b0));
		plan.push_back(row_item("G", 1'b1));
		// step shrinks under the running phase mid-sequence: phase wraps
		plan.push_back(row_cfg(swhc_pkg::CFG_STEP_LENGTH, 5));
		plan.push_back(row_item("A", 1'b0));
		plan.push_back(row_item("C", 1'b0));
		plan.push_back(row_item("G", 1'b0));
		plan.push_back(row_cfg(swhc_pkg::CFG_STEP_LENGTH, 2));
		plan.push_back(row_item("T", 1'b0));
		plan.push_back(row_item("R", 1'b1));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain_reports();
				write_reg(plan[i].which, plan[i].value);
			end else if (plan[i].typed) begin
				offer_residue(plan[i].residue, plan[i].eos);
				tally_residue(plan[i].residue, plan[i].eos, reps, n);
				if (plan[i].has_rep) pending_reports.push_back(plan[i].rep);
			end else begin
				feed(plan[i].residue, plan[i].eos);
			end
		end

		// Back-pressure: every residue after the first reports at window 1 / step 1, and the
		// receiver sits still for a long stretch while residues keep coming.
		drain_reports();
		write_reg(swhc_pkg::CFG_WINDOW_SIZE, 1);
		write_reg(swhc_pkg::CFG_STEP_LENGTH, 1);
		quiet    = 1'b1;
		hold_out = 1'b1;
		for (int i = 0; i < 40; i++) feed("A", i == 39);
		quiet = 1'b0;
		drain_reports();

		// Random part: mostly small windows so reports come often; the window
		// is changed only between sequences, step and mask also mid-sequence.
		random_fed = 0;
		while (random_fed < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 5) == 0);
			drain_reports();
			if (seq_pos == 0 && $urandom_range(0, 3) != 0) begin
				sel = $urandom_range(0, 99);
				if (sel < 8)       v = 0;
				else if (sel < 70) v = $urandom_range(1, 16);
				else if (sel < 88) v = $urandom_range(17, 64);
				else if (sel < 94) v = swhc_pkg::MAX_WINDOW;
				else               v = $urandom_range(swhc_pkg::MAX_WINDOW + 1, 17'h1FFFF);
				write_reg(swhc_pkg::CFG_WINDOW_SIZE, v);
			end
			win = active_window();
			if ($urandom_range(0, 2) != 0) begin
				sel = $urandom_range(0, 99);
				if (sel < 12)      v = 0;
				else if (sel < 75) v = $urandom_range(1, win);
				else               v = $urandom_range(win + 1,
					(win > 40000) ? 17'h1FFFF : 2 * win + 3);
				write_reg(swhc_pkg::CFG_STEP_LENGTH, v);
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(swhc_pkg::CFG_LOWER_IS_MASKED, $urandom_range(0, 1));

			nseq      = $urandom_range(1, 4);
			open_tail = ($urandom_range(0, 3) == 0);
			for (int s = 0; s < nseq; s++) begin
				len = (win <= 64) ? $urandom_range(1, 3 * win + 12) : $urandom_range(1, 40);
				for (int i = 0; i < len && random_fed < RANDOM_ITEMS; i++) begin
					feed(pick_residue(), i == len - 1 && !(s == nseq - 1 && open_tail));
					random_fed++;
					// sender now and then waits for all reports before going on
					if ($urandom_range(0, 299) == 0) drain_reports();
				end
			end
		end
		if (seq_pos != 0) feed(pick_residue(), 1'b1);
		quiet = 1'b0;
		drain_reports();

		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run ceiling, well above the slowest legal run
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
